/* rtl/usan_pkg.sv */
// Package for the UTF-8 sanitizer: payload structs, byte classes and constants.
// No dependencies; used by usan_front, usan_back and utf8_sanitizer.
`timescale 1ns / 1ps
package usan_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_run_end;
      logic       out_stream_end;
   } rsp_type;

   // class of a raw byte, as lead and as follower
   typedef enum logic [2:0] {
      CL_ASCII,
      CL_LEAD2,
      CL_LEAD3,
      CL_LEAD4,
      CL_CONT,
      CL_INVALID
   } cls_type;

   typedef struct packed {
      logic [7:0] data;
      cls_type    cls;
   } slot_type;

   // entry of the queue between front and back
   typedef struct packed {
      slot_type slot;
      logic     last;
   } qent_type;

   localparam logic [7:0] BYTE_80   = 8'h80;
   localparam logic [7:0] BYTE_C0   = 8'hC0;
   localparam logic [7:0] BYTE_C2   = 8'hC2;
   localparam logic [7:0] BYTE_DF   = 8'hDF;
   localparam logic [7:0] BYTE_E0   = 8'hE0;
   localparam logic [7:0] BYTE_ED   = 8'hED;
   localparam logic [7:0] BYTE_EF   = 8'hEF;
   localparam logic [7:0] BYTE_F0   = 8'hF0;
   localparam logic [7:0] BYTE_F4   = 8'hF4;
   localparam logic [7:0] BYTE_A0   = 8'hA0;
   localparam logic [7:0] BYTE_90   = 8'h90;

   // U+FFFD in UTF-8
   localparam logic [7:0] REPL_B0   = 8'hEF;
   localparam logic [7:0] REPL_B1   = 8'hBF;
   localparam logic [7:0] REPL_B2   = 8'hBD;

endpackage

/* rtl/usan_front.sv */
// Front of the UTF-8 sanitizer: takes request bytes, classifies them and
// queues them in a two-entry FIFO for the back end. Depends on usan_pkg.
`timescale 1ns / 1ps
module usan_front import usan_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   output qent_type q_data,
   input  logic     q_pop
);

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      if (b < BYTE_80) begin
         c = CL_ASCII;
      end else if ((b & BYTE_C0) == BYTE_80) begin
         c = CL_CONT;
      end else if (b >= BYTE_C2 && b <= BYTE_DF) begin
         c = CL_LEAD2;
      end else if (b >= BYTE_E0 && b <= BYTE_EF) begin
         c = CL_LEAD3;
      end else if (b >= BYTE_F0 && b <= BYTE_F4) begin
         c = CL_LEAD4;
      end else begin
         c = CL_INVALID;
      end
      return c;
   endfunction

   qent_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;
   qent_type   ent;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      ent.slot.data = req_data.in_byte;
      ent.slot.cls  = classify(req_data.in_byte);
      ent.last      = req_data.in_last;
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= ent;
      end
   end

endmodule

/* rtl/usan_back.sv */
// Back end of the UTF-8 sanitizer: holds undecided bytes, decides each
// sequence and emits one response byte per cycle while the receiver accepts them. Depends on usan_pkg.
`timescale 1ns / 1ps
module usan_back import usan_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  qent_type q_data,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       emit;
      logic       repl;
      logic [2:0] len;
   } dec_type;

   function automatic logic [2:0] len_of(input cls_type c);
      logic [2:0] l;
      unique case (c)
         CL_ASCII: l = 3'd1;
         CL_LEAD2: l = 3'd2;
         CL_LEAD3: l = 3'd3;
         CL_LEAD4: l = 3'd4;
         default:  l = 3'd0;
      endcase
      return l;
   endfunction

   function automatic logic second_ok(input logic [7:0] b0, input logic [7:0] b1);
      logic ok;
      ok = 1'b1;
      if (b0 == BYTE_E0 && b1 < BYTE_A0) ok = 1'b0;
      if (b0 == BYTE_ED && b1 >= BYTE_A0) ok = 1'b0;
      if (b0 == BYTE_F0 && b1 < BYTE_90) ok = 1'b0;
      if (b0 == BYTE_F4 && b1 >= BYTE_90) ok = 1'b0;
      return ok;
   endfunction

   function automatic dec_type decide(input slot_type [3:0] s, input logic [2:0] n,
                                      input logic last);
      dec_type    d;
      logic [2:0] need;
      logic       bad;
      d.emit = 1'b0;
      d.repl = 1'b0;
      d.len  = 3'd1;
      need   = len_of(s[0].cls);
      bad    = 1'b0;
      for (int k = 1; k < 4; k++) begin
         if (3'(k) < need && 3'(k) < n && s[k].cls != CL_CONT) bad = 1'b1;
      end
      if (n != 3'd0) begin
         if (need == 3'd0 || bad) begin
            d.emit = 1'b1;
            d.repl = 1'b1;
         end else if (n >= need) begin
            d.emit = 1'b1;
            if (need >= 3'd3 && !second_ok(s[0].data, s[1].data)) begin
               d.repl = 1'b1;
            end else begin
               d.len = need;
            end
         end else if (last) begin
            d.emit = 1'b1;
            d.repl = 1'b1;
         end
      end
      return d;
   endfunction

   function automatic slot_type [3:0] shift(input slot_type [3:0] s, input logic [2:0] sh);
      slot_type [3:0] r;
      int             j;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         j = i + int'(sh);
         if (j < 4) r[i] = s[j];
      end
      return r;
   endfunction

   function automatic logic [7:0] repl_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = REPL_B0;
         2'd1:    b = REPL_B1;
         default: b = REPL_B2;
      endcase
      return b;
   endfunction

   state_type      state_ff, state_in;
   slot_type [3:0] buf_ff, buf_in;
   logic [2:0]     n_ff, n_in;
   logic           last_ff, last_in;
   logic           repl_ff, repl_in;
   logic [1:0]     lidx_ff, lidx_in;
   logic [1:0]     idx_ff, idx_in;
   logic           more_ff, more_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   slot_type [3:0] wb, rb, eb;
   logic [2:0]     wn, rn, cons_d, cons_e;
   logic           wl;
   dec_type        d, d2;
   logic           more;
   logic           space;
   logic           deciding;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign space     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      // working buffer: held bytes plus the queued byte, or the stored remainder
      wb = buf_ff;
      wn = n_ff;
      wl = last_ff;
      if (state_ff == ST_IDLE) begin
         for (int i = 0; i < 4; i++) begin
            if (3'(i) == n_ff) wb[i] = q_data.slot;
         end
         wn = n_ff + 3'd1;
         wl = q_data.last;
      end
      d      = decide(wb, wn, wl);
      cons_d = d.repl ? 3'd1 : d.len;
      rb     = shift(wb, cons_d);
      rn     = wn - cons_d;
      d2     = decide(rb, rn, wl);
      more   = d2.emit;
      cons_e = repl_ff ? 3'd1 : ({1'b0, lidx_ff} + 3'd1);
      eb     = shift(buf_ff, cons_e);

      deciding = space && ((state_ff == ST_IDLE && q_valid) || state_ff == ST_CHAIN);
      q_pop    = space && state_ff == ST_IDLE && q_valid;

      state_in     = state_ff;
      buf_in       = buf_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      repl_in      = repl_ff;
      lidx_in      = lidx_ff;
      idx_in       = idx_ff;
      more_in      = more_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (deciding) begin
         last_in = wl;
         if (!d.emit) begin
            buf_in   = wb;
            n_in     = wn;
            state_in = ST_IDLE;
         end else begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte = d.repl ? REPL_B0 : wb[0].data;
            if (!d.repl && d.len == 3'd1) begin
               rsp_data_in.out_run_end    = !more;
               rsp_data_in.out_stream_end = !more && wl;
               buf_in   = rb;
               n_in     = rn;
               state_in = more ? ST_CHAIN : ST_IDLE;
            end else begin
               rsp_data_in.out_run_end    = 1'b0;
               rsp_data_in.out_stream_end = 1'b0;
               buf_in   = wb;
               n_in     = wn;
               repl_in  = d.repl;
               lidx_in  = d.repl ? 2'd2 : 2'(d.len - 3'd1);
               idx_in   = 2'd1;
               more_in  = more;
               state_in = ST_EMIT;
            end
         end
      end else if (state_ff == ST_EMIT && space) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = repl_ff ? repl_byte(idx_ff) : buf_ff[idx_ff].data;
         if (idx_ff == lidx_ff) begin
            rsp_data_in.out_run_end    = !more_ff;
            rsp_data_in.out_stream_end = !more_ff && last_ff;
            buf_in   = eb;
            n_in     = n_ff - cons_e;
            state_in = more_ff ? ST_CHAIN : ST_IDLE;
         end else begin
            rsp_data_in.out_run_end    = 1'b0;
            rsp_data_in.out_stream_end = 1'b0;
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      buf_ff      <= buf_in;
      last_ff     <= last_in;
      repl_ff     <= repl_in;
      lidx_ff     <= lidx_in;
      idx_ff      <= idx_in;
      more_ff     <= more_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/utf8_sanitizer.sv */
// UTF-8 sanitizer top level: request byte stream in, cleaned byte stream out.
// Depends on usan_pkg, usan_front and usan_back.
//
// Requests (req_valid/req_ready/req_data) carry one raw byte and a flag that
// marks the last byte of a buffer. Responses (rsp_valid/rsp_ready/rsp_data)
// carry one output byte each; out_run_end marks the last byte released by a
// request and out_stream_end the last byte of the buffer. Malformed input is
// replaced by EF BF BD, one replacement per dropped byte.
// A request may release nothing (bytes held for an incomplete sequence) or up
// to twelve bytes (end of buffer flushing held bytes).
// A request byte passes through the queue and then the response register before
// its first response byte is valid. The back end emits one byte per cycle while
// rsp_ready allows; a replaced byte yields three output bytes.
// A two-entry queue separates classification from emission, so requests keep
// flowing while the back end works or the receiver stalls; when the receiver
// holds rsp_ready low the response register holds its byte and the queue
// fills, then req_ready drops.
// Reset empties the queue, the held bytes and the response register.
`timescale 1ns / 1ps
module utf8_sanitizer import usan_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     q_valid;
   logic     q_pop;
   qent_type q_data;

   usan_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   usan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
